/* rtl/wsf_pkg.sv */
package wsf_pkg;

  localparam int COORD_W          = 32;
  localparam int DIFF_W           = 33;
  localparam int SCALE_LIMIT_BITS = 15;
  localparam int SH_W             = 5;
  localparam int SH_MAX           = DIFF_W - SCALE_LIMIT_BITS;
  localparam int RED_W            = 17;
  localparam int BV_W             = 18;
  localparam int ROOT_FRAC        = 15;
  localparam int PROJ_FRAC        = 16;
  localparam int CMAG_W           = 32;
  localparam int N_W              = 64;
  localparam int DAM_W            = 32;
  localparam int DBM_W            = 33;
  localparam int NA_W             = 32;
  localparam int NB_W             = 34;
  localparam int SQ_W             = 64;
  localparam int ROOT_W           = SQ_W / 2;
  localparam int PQ_W             = 34;
  localparam int PF_W             = 35;
  localparam int PROD_W           = CMAG_W + PF_W;
  localparam int Q_W              = 32;
  localparam int SHIFT_W          = 6;

  typedef struct packed {
    logic [2:0]                   neg;
    logic [2:0][CMAG_W-1:0]       cmag;
    logic [N_W-1:0]               n;
    logic [SH_W-1:0]              sh;
  } core_t;

  typedef struct packed {
    core_t                        core;
    logic [DAM_W-1:0]             dam;
    logic [DBM_W-1:0]             dbm;
  } proj_t;

  typedef struct packed {
    proj_t                        proj;
    logic [NA_W-1:0]              na;
    logic [NB_W-1:0]              nb;
  } geom_t;

  typedef struct packed {
    logic [2:0]                   neg;
    logic [2:0]                   big;
    logic                         degen;
  } fin_t;

  function automatic logic [DIFF_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] n;
    n = -v;
    return v[DIFF_W-1] ? DIFF_W'(n) : DIFF_W'(v);
  endfunction

  function automatic logic [SH_W-1:0] scale_shift(input logic [DIFF_W-1:0] m);
    logic [SH_W-1:0] s;
    s = '0;
    for (int i = SCALE_LIMIT_BITS; i < DIFF_W; i++) begin
      if (m[i]) s = SH_W'(i + 1 - SCALE_LIMIT_BITS);
    end
    return s;
  endfunction

endpackage

/* rtl/wsf_geom.sv */
module wsf_geom (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [2:0][wsf_pkg::COORD_W-1:0]       pt,
  input  logic [2:0][wsf_pkg::COORD_W-1:0]       st,
  input  logic [2:0][wsf_pkg::COORD_W-1:0]       et,
  output logic                                   out_valid,
  output wsf_pkg::geom_t                         out_geom
);

  localparam int DW = wsf_pkg::DIFF_W;
  localparam int RW = wsf_pkg::RED_W;
  localparam int BW = wsf_pkg::BV_W;

  logic [7:0]                          v_r;
  logic signed [DW-1:0]                w1_r [3];
  logic signed [DW-1:0]                a1_r [3];
  logic signed [DW-1:0]                w2_r [3];
  logic signed [DW-1:0]                a2_r [3];
  logic [DW-1:0]                       m2_r;
  logic [DW-1:0]                       m_c;
  logic signed [DW-1:0]                w3_r [3];
  logic signed [DW-1:0]                a3_r [3];
  logic [wsf_pkg::SH_W-1:0]            sh3_r;
  logic signed [RW-1:0]                wc [3];
  logic signed [RW-1:0]                ac [3];
  logic signed [RW-1:0]                w4_r [3];
  logic signed [RW-1:0]                a4_r [3];
  logic signed [BW-1:0]                b4_r [3];
  logic [wsf_pkg::SH_W-1:0]            sh4_r;
  logic signed [31:0]                  cp5_r [3];
  logic signed [31:0]                  cm5_r [3];
  logic signed [31:0]                  aw5_r [3];
  logic signed [31:0]                  aa5_r [3];
  logic signed [32:0]                  bw5_r [3];
  logic signed [33:0]                  bb5_r [3];
  logic [wsf_pkg::SH_W-1:0]            sh5_r;
  logic signed [32:0]                  c6_r [3];
  logic signed [33:0]                  da6_r;
  logic signed [33:0]                  db6_r;
  logic signed [33:0]                  nda_c;
  logic signed [33:0]                  ndb_c;
  logic [wsf_pkg::NA_W-1:0]            na6_r;
  logic [wsf_pkg::NB_W-1:0]            nb6_r;
  logic [wsf_pkg::SH_W-1:0]            sh6_r;
  logic [2:0][wsf_pkg::CMAG_W-1:0]     cm_c;
  logic [2:0]                          neg7_r;
  logic [2:0][wsf_pkg::CMAG_W-1:0]     cmag7_r;
  logic [wsf_pkg::N_W-1:0]             cc7_r [3];
  logic [wsf_pkg::DAM_W-1:0]           dam7_r;
  logic [wsf_pkg::DBM_W-1:0]           dbm7_r;
  logic [wsf_pkg::NA_W-1:0]            na7_r;
  logic [wsf_pkg::NB_W-1:0]            nb7_r;
  logic [wsf_pkg::SH_W-1:0]            sh7_r;
  wsf_pkg::geom_t                      g8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:0], in_valid};
    end
  end

  always_comb begin
    m_c = '0;
    for (int i = 0; i < 3; i++) begin
      if (wsf_pkg::mag_diff(w1_r[i]) > m_c) m_c = wsf_pkg::mag_diff(w1_r[i]);
      if (wsf_pkg::mag_diff(a1_r[i]) > m_c) m_c = wsf_pkg::mag_diff(a1_r[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wc[i] = RW'(w3_r[i] >>> sh3_r);
      ac[i] = RW'(a3_r[i] >>> sh3_r);
      cm_c[i] = wsf_pkg::CMAG_W'(wsf_pkg::mag_diff(c6_r[i]));
    end
    nda_c = -da6_r;
    ndb_c = -db6_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        w1_r[i] <= $signed({et[i][31], et[i]}) - $signed({st[i][31], st[i]});
        a1_r[i] <= $signed({pt[i][31], pt[i]}) - $signed({st[i][31], st[i]});
        w2_r[i] <= w1_r[i];
        a2_r[i] <= a1_r[i];
        w3_r[i] <= w2_r[i];
        a3_r[i] <= a2_r[i];
        w4_r[i] <= wc[i];
        a4_r[i] <= ac[i];
        b4_r[i] <= BW'(ac[i]) - BW'(wc[i]);
        aw5_r[i] <= 32'(a4_r[i]) * 32'(w4_r[i]);
        aa5_r[i] <= 32'(a4_r[i]) * 32'(a4_r[i]);
        bw5_r[i] <= 33'(b4_r[i]) * 33'(w4_r[i]);
        bb5_r[i] <= 34'(b4_r[i]) * 34'(b4_r[i]);
        c6_r[i]  <= 33'(cp5_r[i]) - 33'(cm5_r[i]);
        neg7_r[i] <= c6_r[i][32];
        cmag7_r[i] <= cm_c[i];
        cc7_r[i] <= cm_c[i] * cm_c[i];
      end
      m2_r  <= m_c;
      sh3_r <= wsf_pkg::scale_shift(m2_r);
      sh4_r <= sh3_r;
      cp5_r[0] <= 32'(w4_r[1]) * 32'(a4_r[2]);
      cm5_r[0] <= 32'(w4_r[2]) * 32'(a4_r[1]);
      cp5_r[1] <= 32'(w4_r[2]) * 32'(a4_r[0]);
      cm5_r[1] <= 32'(w4_r[0]) * 32'(a4_r[2]);
      cp5_r[2] <= 32'(w4_r[0]) * 32'(a4_r[1]);
      cm5_r[2] <= 32'(w4_r[1]) * 32'(a4_r[0]);
      sh5_r <= sh4_r;
      da6_r <= 34'(aw5_r[0]) + 34'(aw5_r[1]) + 34'(aw5_r[2]);
      db6_r <= 34'(bw5_r[0]) + 34'(bw5_r[1]) + 34'(bw5_r[2]);
      na6_r <= wsf_pkg::NA_W'($unsigned(aa5_r[0])) + wsf_pkg::NA_W'($unsigned(aa5_r[1]))
             + wsf_pkg::NA_W'($unsigned(aa5_r[2]));
      nb6_r <= wsf_pkg::NB_W'($unsigned(bb5_r[0])) + wsf_pkg::NB_W'($unsigned(bb5_r[1]))
             + wsf_pkg::NB_W'($unsigned(bb5_r[2]));
      sh6_r <= sh5_r;
      dam7_r <= wsf_pkg::DAM_W'(da6_r[33] ? nda_c : da6_r);
      dbm7_r <= wsf_pkg::DBM_W'(db6_r[33] ? ndb_c : db6_r);
      na7_r <= na6_r;
      nb7_r <= nb6_r;
      sh7_r <= sh6_r;
      g8_r.proj.core.neg  <= neg7_r;
      g8_r.proj.core.cmag <= cmag7_r;
      g8_r.proj.core.n    <= cc7_r[0] + cc7_r[1] + cc7_r[2];
      g8_r.proj.core.sh   <= sh7_r;
      g8_r.proj.dam       <= dam7_r;
      g8_r.proj.dbm       <= dbm7_r;
      g8_r.na             <= na7_r;
      g8_r.nb             <= nb7_r;
    end
  end

  assign out_valid = v_r[7];
  assign out_geom  = g8_r;

endmodule

/* rtl/wsf_isqrt.sv */
module wsf_isqrt #(
  parameter int LANES  = 2,
  parameter int XW     = 64,
  parameter int SIDE_W = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [LANES-1:0][XW-1:0]      x,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic [LANES-1:0][XW/2-1:0]    root,
  output logic [SIDE_W-1:0]             out_side
);

  localparam int RW = XW / 2;

  logic [RW-1:0]                   v_r;
  logic [LANES-1:0][XW-1:0]        rem_r  [RW-1];
  logic [LANES-1:0][RW-1:0]        rt_r   [RW];
  logic [SIDE_W-1:0]               side_r [RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[RW-2:0], in_valid};
    end
  end

  genvar s;
  generate
    for (s = 0; s < RW; s++) begin : g_stage
      localparam int B = RW - 1 - s;
      logic [LANES-1:0][XW-1:0]  rem_i;
      logic [LANES-1:0][XW-1:0]  rem_o;
      logic [LANES-1:0][RW-1:0]  rt_i;
      logic [LANES-1:0][RW-1:0]  rt_o;
      logic [SIDE_W-1:0]         side_i;

      if (s == 0) begin : g_first
        assign rem_i  = x;
        assign rt_i   = '0;
        assign side_i = in_side;
      end else begin : g_next
        assign rem_i  = rem_r[s-1];
        assign rt_i   = rt_r[s-1];
        assign side_i = side_r[s-1];
      end

      always_comb begin
        logic [XW:0] t;
        logic [XW:0] rx;
        for (int l = 0; l < LANES; l++) begin
          t  = ((XW+1)'(rt_i[l]) << (B + 1)) | ((XW+1)'(1) << (2 * B));
          rx = (XW+1)'(rem_i[l]);
          if (rx >= t) begin
            rem_o[l] = XW'(rx - t);
            rt_o[l]  = rt_i[l] | (RW'(1) << B);
          end else begin
            rem_o[l] = rem_i[l];
            rt_o[l]  = rt_i[l];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rt_r[s]   <= rt_o;
          side_r[s] <= side_i;
        end
      end

      if (s < RW - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[s] <= rem_o;
          end
        end
      end
    end
  endgenerate

  assign out_valid = v_r[RW-1];
  assign root      = rt_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

/* rtl/wsf_div.sv */
module wsf_div #(
  parameter int LANES  = 2,
  parameter int NW     = 64,
  parameter int DW     = 32,
  parameter int QW     = 34,
  parameter int SIDE_W = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [LANES-1:0][NW-1:0]      num,
  input  logic [LANES-1:0][DW-1:0]      den,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic [LANES-1:0][QW-1:0]      quo,
  output logic [SIDE_W-1:0]             out_side
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [QW-1:0]                   v_r;
  logic [LANES-1:0][NW-1:0]        rem_r  [QW-1];
  logic [LANES-1:0][DW-1:0]        den_r  [QW-1];
  logic [LANES-1:0][QW-1:0]        q_r    [QW];
  logic [SIDE_W-1:0]               side_r [QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-2:0], in_valid};
    end
  end

  genvar s;
  generate
    for (s = 0; s < QW; s++) begin : g_stage
      localparam int B = QW - 1 - s;
      logic [LANES-1:0][NW-1:0]  rem_i;
      logic [LANES-1:0][NW-1:0]  rem_o;
      logic [LANES-1:0][DW-1:0]  den_i;
      logic [LANES-1:0][QW-1:0]  q_i;
      logic [LANES-1:0][QW-1:0]  q_o;
      logic [SIDE_W-1:0]         side_i;

      if (s == 0) begin : g_first
        assign rem_i  = num;
        assign den_i  = den;
        assign q_i    = '0;
        assign side_i = in_side;
      end else begin : g_next
        assign rem_i  = rem_r[s-1];
        assign den_i  = den_r[s-1];
        assign q_i    = q_r[s-1];
        assign side_i = side_r[s-1];
      end

      always_comb begin
        logic [CW-1:0] dsh;
        logic [CW-1:0] rx;
        for (int l = 0; l < LANES; l++) begin
          dsh = CW'(den_i[l]) << B;
          rx  = CW'(rem_i[l]);
          if (rx >= dsh) begin
            rem_o[l] = NW'(rx - dsh);
            q_o[l]   = q_i[l] | (QW'(1) << B);
          end else begin
            rem_o[l] = rem_i[l];
            q_o[l]   = q_i[l];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          q_r[s]    <= q_o;
          side_r[s] <= side_i;
        end
      end

      if (s < QW - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[s] <= rem_o;
            den_r[s] <= den_i;
          end
        end
      end
    end
  endgenerate

  assign out_valid = v_r[QW-1];
  assign quo       = q_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

/* rtl/wire_segment_field_top.sv */
// Field of a finite straight wire segment at a point, Q16.16 in and out.
// Input channel: in_valid / in_stall with the point and both segment ends.
// Output channel: out_valid / out_stall with field_x/y/z, degenerate and
// saturated. A transaction moves at a clock edge where valid is high and
// stall is low.
// Throughput: one transaction per cycle while in_stall is low.
// The pipeline is a stage chain: 8 geometry stages, a 32-stage
// square root, a 34-stage projection divider, 4 scaling stages, a 32-stage
// field divider and the output register.
// Reset (rst_n low, synchronous) clears every valid bit; items in flight are
// dropped and out_valid falls.
// When out_stall holds a result, one more result is caught in a skid
// register; in_stall then rises and the whole pipeline holds until the
// output drains.
// COORD_FRAC_BITS sets the fraction bits of the coordinates and of the field.
module wire_segment_field_top #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_point_x,
  input  logic [31:0] in_point_y,
  input  logic [31:0] in_point_z,
  input  logic [31:0] in_seg_start_x,
  input  logic [31:0] in_seg_start_y,
  input  logic [31:0] in_seg_start_z,
  input  logic [31:0] in_seg_end_x,
  input  logic [31:0] in_seg_end_y,
  input  logic [31:0] in_seg_end_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_field_x,
  output logic [31:0] out_field_y,
  output logic [31:0] out_field_z,
  output logic        out_degenerate,
  output logic        out_saturated
);

  localparam int KBASE    = 2 * COORD_FRAC_BITS - wsf_pkg::PROJ_FRAC;
  localparam int KPOS_MAX = (KBASE > 0) ? KBASE : 0;
  localparam int KNEG_MAX = (wsf_pkg::SH_MAX > KBASE) ? wsf_pkg::SH_MAX - KBASE : 0;
  localparam int NUMW     = wsf_pkg::PROD_W + KPOS_MAX;
  localparam int DENW     = wsf_pkg::N_W + KNEG_MAX;
  localparam int CMPW     = (NUMW > DENW + wsf_pkg::Q_W) ? NUMW : DENW + wsf_pkg::Q_W;
  localparam int SQ_SW    = $bits(wsf_pkg::proj_t);
  localparam int D1_SW    = $bits(wsf_pkg::core_t);
  localparam int D2_SW    = $bits(wsf_pkg::fin_t);

  typedef struct packed {
    logic [2:0][31:0] field;
    logic             degen;
    logic             sat;
  } res_t;

  logic                                     adv;
  logic                                     push;
  logic                                     g_valid;
  wsf_pkg::geom_t                           g_geom;
  logic [1:0][wsf_pkg::SQ_W-1:0]            sq_x;
  logic                                     sq_valid;
  logic [1:0][wsf_pkg::ROOT_W-1:0]          sq_root;
  wsf_pkg::proj_t                           sq_side;
  logic [1:0][wsf_pkg::SQ_W-1:0]            d1_num;
  logic                                     d1_valid;
  logic [1:0][wsf_pkg::PQ_W-1:0]            d1_quo;
  wsf_pkg::core_t                           d1_side;
  logic [3:0]                               tv_r;
  logic [wsf_pkg::PF_W-1:0]                 pf1_r;
  wsf_pkg::core_t                           core1_r;
  logic [2:0][wsf_pkg::PROD_W-1:0]          prod2_r;
  logic [2:0]                               neg2_r;
  logic [wsf_pkg::N_W-1:0]                  n2_r;
  logic [wsf_pkg::SH_W-1:0]                 sh2_r;
  logic [wsf_pkg::SHIFT_W-1:0]              kpos_c;
  logic [wsf_pkg::SHIFT_W-1:0]              kneg_c;
  logic [2:0][NUMW-1:0]                     num3_r;
  logic [DENW-1:0]                          den3_r;
  logic                                     degen3_r;
  logic [2:0]                               neg3_r;
  logic [2:0]                               big_c;
  logic [2:0][NUMW-1:0]                     num4_r;
  logic [DENW-1:0]                          den4_r;
  wsf_pkg::fin_t                            fin4_r;
  logic [2:0][DENW-1:0]                     d2_den;
  logic                                     d2_valid;
  logic [2:0][wsf_pkg::Q_W-1:0]             d2_quo;
  wsf_pkg::fin_t                            d2_side;
  res_t                                     res_c;
  res_t                                     out_r;
  res_t                                     skid_r;
  logic                                     out_v_r;
  logic                                     skid_v_r;

  assign adv      = !skid_v_r;
  assign in_stall = !adv;

  wsf_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_valid),
    .pt        ({in_point_z, in_point_y, in_point_x}),
    .st        ({in_seg_start_z, in_seg_start_y, in_seg_start_x}),
    .et        ({in_seg_end_z, in_seg_end_y, in_seg_end_x}),
    .out_valid (g_valid),
    .out_geom  (g_geom)
  );

  assign sq_x[0] = wsf_pkg::SQ_W'(g_geom.na) << (2 * wsf_pkg::ROOT_FRAC);
  assign sq_x[1] = wsf_pkg::SQ_W'(g_geom.nb) << (2 * wsf_pkg::ROOT_FRAC);

  wsf_isqrt #(
    .LANES  (2),
    .XW     (wsf_pkg::SQ_W),
    .SIDE_W (SQ_SW)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (g_valid),
    .x         (sq_x),
    .in_side   (g_geom.proj),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  assign d1_num[0] = wsf_pkg::SQ_W'(sq_side.dam) << (wsf_pkg::PROJ_FRAC + wsf_pkg::ROOT_FRAC);
  assign d1_num[1] = wsf_pkg::SQ_W'(sq_side.dbm) << (wsf_pkg::PROJ_FRAC + wsf_pkg::ROOT_FRAC);

  wsf_div #(
    .LANES  (2),
    .NW     (wsf_pkg::SQ_W),
    .DW     (wsf_pkg::ROOT_W),
    .QW     (wsf_pkg::PQ_W),
    .SIDE_W (D1_SW)
  ) u_div_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (sq_valid),
    .num       (d1_num),
    .den       (sq_root),
    .in_side   (sq_side.core),
    .out_valid (d1_valid),
    .quo       (d1_quo),
    .out_side  (d1_side)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= '0;
    end else if (adv) begin
      tv_r <= {tv_r[2:0], d1_valid};
    end
  end

  always_comb begin
    kpos_c = (KBASE > int'(sh2_r)) ? wsf_pkg::SHIFT_W'(KBASE - int'(sh2_r)) : '0;
    kneg_c = (int'(sh2_r) > KBASE) ? wsf_pkg::SHIFT_W'(int'(sh2_r) - KBASE) : '0;
    for (int i = 0; i < 3; i++) begin
      big_c[i] = CMPW'(num3_r[i]) >= (CMPW'(den3_r) << wsf_pkg::Q_W);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pf1_r   <= wsf_pkg::PF_W'(d1_quo[0]) + wsf_pkg::PF_W'(d1_quo[1]);
      core1_r <= d1_side;
      for (int i = 0; i < 3; i++) begin
        prod2_r[i] <= core1_r.cmag[i] * pf1_r;
        num3_r[i]  <= NUMW'(prod2_r[i]) << kpos_c;
        num4_r[i]  <= big_c[i] ? '0 : num3_r[i];
      end
      neg2_r       <= core1_r.neg;
      n2_r         <= core1_r.n;
      sh2_r        <= core1_r.sh;
      den3_r       <= DENW'(n2_r) << kneg_c;
      degen3_r     <= (n2_r == '0);
      neg3_r       <= neg2_r;
      den4_r       <= den3_r;
      fin4_r.neg   <= neg3_r;
      fin4_r.big   <= big_c;
      fin4_r.degen <= degen3_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d2_den[i] = den4_r;
    end
  end

  wsf_div #(
    .LANES  (3),
    .NW     (NUMW),
    .DW     (DENW),
    .QW     (wsf_pkg::Q_W),
    .SIDE_W (D2_SW)
  ) u_div_field (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (tv_r[3]),
    .num       (num4_r),
    .den       (d2_den),
    .in_side   (fin4_r),
    .out_valid (d2_valid),
    .quo       (d2_quo),
    .out_side  (d2_side)
  );

  always_comb begin
    res_c.degen = d2_side.degen;
    res_c.sat   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (d2_side.degen) begin
        res_c.field[i] = '0;
      end else if (d2_side.neg[i]) begin
        if (d2_side.big[i] || d2_quo[i] > 32'h8000_0000) begin
          res_c.field[i] = 32'h8000_0000;
          res_c.sat      = 1'b1;
        end else begin
          res_c.field[i] = 32'd0 - d2_quo[i];
        end
      end else begin
        if (d2_side.big[i] || d2_quo[i][31]) begin
          res_c.field[i] = 32'h7FFF_FFFF;
          res_c.sat      = 1'b1;
        end else begin
          res_c.field[i] = d2_quo[i];
        end
      end
    end
  end

  assign push = adv && d2_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      out_v_r  <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || !out_stall) begin
      out_r <= skid_v_r ? skid_r : res_c;
    end else if (push) begin
      skid_r <= res_c;
    end
  end

  assign out_valid      = out_v_r;
  assign out_field_x    = out_r.field[0];
  assign out_field_y    = out_r.field[1];
  assign out_field_z    = out_r.field[2];
  assign out_degenerate = out_r.degen;
  assign out_saturated  = out_r.sat;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a transaction while the output is empty");

  a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall && push) |=> skid_v_r)
    else $error("transaction pushed into a held output was dropped");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.degen) |-> (out_r.field == '0 && !out_r.sat))
    else $error("degenerate result carries a nonzero field");

endmodule

/* tb/wire_segment_field_checker.sv */
`timescale 1ns / 1ps
module wire_segment_field_checker #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_point_x,
  input  logic [31:0] in_point_y,
  input  logic [31:0] in_point_z,
  input  logic [31:0] in_seg_start_x,
  input  logic [31:0] in_seg_start_y,
  input  logic [31:0] in_seg_start_z,
  input  logic [31:0] in_seg_end_x,
  input  logic [31:0] in_seg_end_y,
  input  logic [31:0] in_seg_end_z,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_field_x,
  input  logic [31:0] out_field_y,
  input  logic [31:0] out_field_z,
  input  logic        out_degenerate,
  input  logic        out_saturated,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] fz;
    logic        degen;
    logic        sat;
  } field_t;

  field_t field_q[$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] rem, res, b;
    rem = x;
    res = 0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint sdiv_floor(input longint v, input int n);
    return v >>> n;
  endfunction

  function automatic longint absl(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic field_t compute_field(input logic [31:0] pt[3], input logic [31:0] st[3],
                                           input logic [31:0] en[3]);
    longint w[3], a[3], ww[3], aa[3], bv[3], c[3];
    longint m, da, db;
    logic [63:0] n, na, nb, la, lb, pf;
    logic [255:0] num, den, q;
    int len, sh, k;
    field_t r;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      w[i] = longint'($signed(en[i])) - longint'($signed(st[i]));
      a[i] = longint'($signed(pt[i])) - longint'($signed(st[i]));
      if (absl(w[i]) > m) m = absl(w[i]);
      if (absl(a[i]) > m) m = absl(a[i]);
    end
    len = 0;
    while (len < 63 && (m >> len) != 0) len++;
    sh = len > 15 ? len - 15 : 0;
    for (int i = 0; i < 3; i++) begin
      ww[i] = sdiv_floor(w[i], sh);
      aa[i] = sdiv_floor(a[i], sh);
      bv[i] = aa[i] - ww[i];
    end
    c[0] = ww[1] * aa[2] - ww[2] * aa[1];
    c[1] = ww[2] * aa[0] - ww[0] * aa[2];
    c[2] = ww[0] * aa[1] - ww[1] * aa[0];
    n = 0; na = 0; nb = 0; da = 0; db = 0;
    for (int i = 0; i < 3; i++) begin
      n += 64'(absl(c[i])) * 64'(absl(c[i]));
      da += aa[i] * ww[i];
      db += bv[i] * ww[i];
      na += 64'(aa[i] * aa[i]);
      nb += 64'(bv[i] * bv[i]);
    end
    r = '0;
    if (n == 0) begin
      r.degen = 1'b1;
      return r;
    end
    la = int_sqrt(na << 30);
    lb = int_sqrt(nb << 30);
    pf = (64'(absl(da)) << 31) / la + (64'(absl(db)) << 31) / lb;
    k = 2 * COORD_FRAC_BITS - sh - 16;
    for (int i = 0; i < 3; i++) begin
      num = 256'(absl(c[i])) * 256'(pf);
      den = 256'(n);
      if (k > 0) num = num << k;
      else den = den << (-k);
      q = num / den;
      if (c[i] < 0) begin
        if (q > 256'h8000_0000) begin
          q = 256'h8000_0000;
          r.sat = 1'b1;
        end
        q = -q;
      end else if (q > 256'h7fff_ffff) begin
        q = 256'h7fff_ffff;
        r.sat = 1'b1;
      end
      if (i == 0) r.fx = q[31:0];
      else if (i == 1) r.fy = q[31:0];
      else r.fz = q[31:0];
    end
    return r;
  endfunction

  assign pending = field_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    field_t exp_f, got;
    if (rst_n && in_valid && !in_stall)
      field_q.push_back(compute_field('{in_point_x, in_point_y, in_point_z},
                                      '{in_seg_start_x, in_seg_start_y, in_seg_start_z},
                                      '{in_seg_end_x, in_seg_end_y, in_seg_end_z}));
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_field_x, out_field_y, out_field_z, out_degenerate, out_saturated};
      if (field_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected transaction: %h", got);
      end else begin
        exp_f = field_q.pop_front();
        if (exp_f !== got) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: exp x=%h y=%h z=%h d=%b s=%b got x=%h y=%h z=%h d=%b s=%b",
                     exp_f.fx, exp_f.fy, exp_f.fz, exp_f.degen, exp_f.sat,
                     got.fx, got.fy, got.fz, got.degen, got.sat);
        end
      end
    end
  end

endmodule

/* tb/tb_wire_segment_field_top.sv */
`timescale 1ns / 1ps
module tb_wire_segment_field_top;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] pt[3];
  logic [31:0] st[3];
  logic [31:0] en[3];
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_field_x, out_field_y, out_field_z;
  logic        out_degenerate, out_saturated;
  int          fail_count, pending;
  int          cycle_count = 0;
  bit          hold_long = 1'b0;
  bit          stall_mode = 1'b0;

  always #2 clk = ~clk;

  initial begin
    for (int i = 0; i < 3; i++) begin
      pt[i] = 0; st[i] = 0; en[i] = 0;
    end
  end

  wire_segment_field_top uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_point_x(pt[0]), .in_point_y(pt[1]), .in_point_z(pt[2]),
    .in_seg_start_x(st[0]), .in_seg_start_y(st[1]), .in_seg_start_z(st[2]),
    .in_seg_end_x(en[0]), .in_seg_end_y(en[1]), .in_seg_end_z(en[2]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_field_x(out_field_x), .out_field_y(out_field_y), .out_field_z(out_field_z),
    .out_degenerate(out_degenerate), .out_saturated(out_saturated)
  );

  wire_segment_field_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_point_x(pt[0]), .in_point_y(pt[1]), .in_point_z(pt[2]),
    .in_seg_start_x(st[0]), .in_seg_start_y(st[1]), .in_seg_start_z(st[2]),
    .in_seg_end_x(en[0]), .in_seg_end_y(en[1]), .in_seg_end_z(en[2]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_field_x(out_field_x), .out_field_y(out_field_y), .out_field_z(out_field_z),
    .out_degenerate(out_degenerate), .out_saturated(out_saturated),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: long hold on request, otherwise a shifting random pattern
  always @(negedge clk) begin
    if (hold_long) out_stall <= 1'b1;
    else if (stall_mode) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= 1'b0;
  end

  initial begin
    repeat (50) @(negedge clk);
    forever begin
      stall_mode = $urandom_range(0, 1);
      repeat ($urandom_range(20, 300)) @(negedge clk);
    end
  end

  initial begin
    wait (rst_n);
    repeat (300) @(negedge clk);
    hold_long = 1'b1;
    repeat (400) @(negedge clk);
    hold_long = 1'b0;
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      3: return 32'($signed($urandom_range(0, 65536 * 8)) - 65536 * 4);
      default: return 32'($signed($urandom_range(0, 65536 * 200)) - 65536 * 100);
    endcase
  endfunction

  // offer one transaction, hold it until accepted
  task automatic send_item(input logic [31:0] p[3], input logic [31:0] s[3],
                           input logic [31:0] e[3]);
    pt = p; st = s; en = e;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic send_random();
    logic [31:0] p[3], s[3], e[3];
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      s[i] = rand_coord();
      e[i] = rand_coord();
      p[i] = rand_coord();
    end
    if (kind == 0) p = s;
    else if (kind == 1) e = s;
    else if (kind == 2) begin
      for (int i = 0; i < 3; i++) begin
        e[i] = s[i] + ($urandom & 32'h0003_ffff);
        p[i] = s[i] + 2 * (e[i] - s[i]);
      end
    end else if (kind == 3) begin
      for (int i = 0; i < 3; i++) p[i] = s[i] + 32'($signed($urandom_range(0, 60)) - 30);
    end
    send_item(p, s, e);
  endtask

  initial begin
    logic [31:0] z[3], one[3], mx[3], mn[3], ex[3], ey[3], ez[3], far[3];
    z = '{0, 0, 0};
    one = '{32'h0001_0000, 0, 0};
    mx = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    mn = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    ex = '{32'h0001_0000, 0, 0};
    ey = '{0, 32'h0001_0000, 0};
    ez = '{0, 0, 32'h0001_0000};
    far = '{32'h0003_0000, 32'h0001_0000, 0};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_item(ey, z, ex);
    send_item(ez, ex, z);
    send_item(z, z, z);
    send_item(z, z, ex);
    send_item(ex, z, ex);
    send_item('{32'h0002_0000, 0, 0}, z, ex);
    send_item(far, z, ex);
    send_item('{32'hfffe_0000, 32'h0001_0000, 0}, z, ex);
    send_item(mx, mn, mx);
    send_item(mn, mx, mn);
    send_item('{32'h7fff_ffff, 0, 0}, mn, '{32'h8000_0000, 1, 0});
    send_item('{0, 1, 0}, z, ex);
    send_item('{0, 0, 1}, '{32'h8000_0000, 0, 0}, '{32'h7fff_ffff, 0, 0});
    send_item(ey, '{32'h8000_0000, 32'h7fff_ffff, 0}, '{32'h7fff_ffff, 32'h8000_0000, 1});
    send_item(mx, z, mn);
    send_item('{1, 1, 1}, z, '{32'hffff_ffff, 0, 0});
    send_item(ez, one, mx);
    gap();
    for (int n = 0; n < 1550; ) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++) begin
        send_random();
        n++;
      end
      if (n > 800 && n < 841) begin
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      if ($urandom_range(0, 2) != 0) gap();
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
